// ----- rtl/core/pitch_set_prime_form_unit_macros.svh -----
// Assertion macros for the pitch set prime form unit.
`ifndef PITCH_SET_PRIME_FORM_UNIT_MACROS_SVH
`define PITCH_SET_PRIME_FORM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSPF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prime form unit: implication check failed");

// Fixed-delay implication.
`define PSPF_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("prime form unit: latency check failed");

`endif

// ----- rtl/core/pspf_pkg.sv -----
// Shared constants and types for the pitch set prime form unit.
package pspf_pkg;

    localparam int PSPF_PITCH_CLASSES = 12;

    // Control that rides with each beat along the cell chain.
    typedef struct packed {
        logic valid;
        logic have;
    } pspf_ctl_t;

endpackage

// ----- rtl/core/pspf_cell.sv -----
// One candidate cell: tests one rotation of the set or its mirror against the running best.
module pspf_cell
    import pspf_pkg::*;
#(
    parameter int N      = PSPF_PITCH_CLASSES,
    parameter int ROT    = 0,
    parameter bit MIRROR = 1'b0,
    localparam int SW    = $clog2(N)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  pspf_ctl_t       in_ctl,
    input  logic [N-1:0]    in_set,
    input  logic [N-1:0]    in_best,
    input  logic [SW-1:0]   in_span,
    output pspf_ctl_t       out_ctl,
    output logic [N-1:0]    out_set,
    output logic [N-1:0]    out_best,
    output logic [SW-1:0]   out_span
);

    pspf_ctl_t       ctl_reg, ctl_next;
    logic [N-1:0]    set_reg;
    logic [N-1:0]    best_reg, best_next;
    logic [SW-1:0]   span_reg, span_next;

    logic [N-1:0]    src;
    logic [2*N-1:0]  dbl;
    logic [N-1:0]    cand;
    logic [SW-1:0]   low;
    logic [SW-1:0]   cand_span;
    logic            member;
    logic            take;

    // inversion is a bit reversal
    always_comb
    begin
        for (int b = 0; b < N; b++)
        begin
            src[b] = MIRROR ? in_set[N-1-b] : in_set[b];
        end
    end

    assign dbl    = {src, src};
    assign cand   = dbl[2*N-1-ROT -: N];
    assign member = src[N-1-ROT];

    // lowest set bit of the candidate gives its highest pitch class
    always_comb
    begin
        low = '0;
        for (int b = N - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                low = SW'(b);
            end
        end
    end

    assign cand_span = SW'(N - 1) - low;

    assign take = in_ctl.valid && member &&
                  (!in_ctl.have || (cand_span < in_span) ||
                   ((cand_span == in_span) && (cand > in_best)));

    always_comb
    begin
        ctl_next.valid = in_ctl.valid;
        ctl_next.have  = in_ctl.have | take;
        best_next      = take ? cand : in_best;
        span_next      = take ? cand_span : in_span;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg  <= in_set;
        best_reg <= best_next;
        span_reg <= span_next;
    end

    assign out_ctl  = ctl_reg;
    assign out_set  = set_reg;
    assign out_best = best_reg;
    assign out_span = span_reg;

endmodule

// ----- rtl/core/pitch_set_prime_form_unit.sv -----
// Top level of the pitch set prime form unit: a chain of candidate cells and an output register.
//
// One set is taken in every cycle; busy stays low, since nothing in the chain can stall.
// The set runs through 2*PITCH_CLASSES cells, one per candidate rotation (first the set,
// then its mirror), each holding one beat and passing it on every cycle; the result is
// on the outputs for one cycle, marked by done, after the last cell and the output register.
// The receiver cannot hold results off, so done must be taken when it shows. An empty set
// gives zero, span zero and is_empty high.
`include "pitch_set_prime_form_unit_macros.svh"

module pitch_set_prime_form_unit
    import pspf_pkg::*;
#(
    parameter int PITCH_CLASSES = PSPF_PITCH_CLASSES,
    localparam int SW           = $clog2(PITCH_CLASSES)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [PITCH_CLASSES-1:0] pitch_set,
    output logic                     done,
    output logic [PITCH_CLASSES-1:0] prime_form,
    output logic [SW-1:0]            span,
    output logic                     is_empty
);

    localparam int N     = PITCH_CLASSES;
    localparam int CELLS = 2 * N;
    localparam int LAT   = CELLS + 1;

    pspf_ctl_t       ctl  [CELLS+1];
    logic [N-1:0]    sets [CELLS+1];
    logic [N-1:0]    best [CELLS+1];
    logic [SW-1:0]   spn  [CELLS+1];

    logic            done_reg;
    logic [N-1:0]    prime_form_reg;
    logic [SW-1:0]   span_reg;
    logic            is_empty_reg;

    assign busy         = 1'b0;
    assign ctl[0].valid = start;
    assign ctl[0].have  = 1'b0;
    assign sets[0]      = pitch_set;
    assign best[0]      = '0;
    assign spn[0]       = '0;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        pspf_cell #(
            .N      (N),
            .ROT    (i % N),
            .MIRROR (i >= N)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctl   (ctl[i]),
            .in_set   (sets[i]),
            .in_best  (best[i]),
            .in_span  (spn[i]),
            .out_ctl  (ctl[i+1]),
            .out_set  (sets[i+1]),
            .out_best (best[i+1]),
            .out_span (spn[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl[CELLS].valid;
        end
    end

    // no candidate was ever taken only for the empty set
    always_ff @(posedge clk)
    begin
        prime_form_reg <= best[CELLS];
        span_reg       <= ctl[CELLS].have ? spn[CELLS] : '0;
        is_empty_reg   <= !ctl[CELLS].have;
    end

    assign done       = done_reg;
    assign prime_form = prime_form_reg;
    assign span       = span_reg;
    assign is_empty   = is_empty_reg;

    `PSPF_ASSERT_DELAY(a_fixed_latency, start, LAT, done)
    `PSPF_ASSERT_IMPL(a_empty_zero, done && is_empty, (prime_form == '0) && (span == '0))
    `PSPF_ASSERT_IMPL(a_root_present, done && !is_empty, prime_form[N-1])
    `PSPF_ASSERT_IMPL(a_span_member, done && !is_empty, prime_form[SW'(N - 1) - span])

endmodule
